### design/swap_slot_bitmap_allocator_assert.svh
// ----------------------------------------------------------------------------
// swap slot bitmap allocator assertion macros
// shared property forms, clocked on clk and gated by rst where noted
// ----------------------------------------------------------------------------
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define SSBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssba check failed");

// next-cycle implication, off during reset
`define SSBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssba check failed");

// next-cycle implication that also runs through reset
`define SSBA_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssba reset check failed");

`endif

### design/ssba_pkg.sv
// ----------------------------------------------------------------------------
// ssba_pkg
// sizes, codes, command/status types and helpers of the slot allocator
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int WORD_BITS  = 32;
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = SLOT_COUNT / WORD_BITS;
  localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SEG_SIZE   = (MAP_WORDS < 16) ? MAP_WORDS : 16;
  localparam int SEG_N      = MAP_WORDS / SEG_SIZE;
  localparam int SEG_AW     = (SEG_SIZE > 1) ? $clog2(SEG_SIZE) : 1;
  localparam int USE_W      = $clog2(SLOT_COUNT + 1);

  localparam int SLOT_W     = 12;
  localparam int TOTAL_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SLOTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_READY  = CFG_IDX_W'(1);

  typedef struct packed {
    logic capture;   // item accepted, latch it and load the group summary
    logic rd_input;  // read the word of the slot being freed
    logic sel;       // pick the first free word and read it
    logic commit;    // write the word back and load the result
  } cmd_t;

  typedef struct packed {
    logic kind;      // kind of the item on the input channel
    logic out_room;  // result register can take a new result
  } sts_t;

  // usable total = min(total_slots, SLOT_COUNT)
  function automatic logic [USE_W-1:0] usable_total(input logic [TOTAL_W-1:0] total);
    logic [USE_W-1:0] res;
    if (32'(total) < 32'(SLOT_COUNT)) begin
      res = USE_W'(total);
    end else begin
      res = USE_W'(SLOT_COUNT);
    end
    return res;
  endfunction

  // lowest clear bit of a word
  function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_AW-1:0] b;
    b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        b = BIT_AW'(i);
      end
    end
    return b;
  endfunction

endpackage

### design/ssba_req_if.sv
// ----------------------------------------------------------------------------
// ssba_req_if
// request channel: allocate or free item
// ----------------------------------------------------------------------------
interface ssba_req_if import ssba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

### design/ssba_rsp_if.sv
// ----------------------------------------------------------------------------
// ssba_rsp_if
// result channel: status and allocated slot
// ----------------------------------------------------------------------------
interface ssba_rsp_if import ssba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] slot_index;
  logic              enabled;

  modport source (output valid, output ok, output slot_index, output enabled, input ready);
  modport sink   (input valid, input ok, input slot_index, input enabled, output ready);
endinterface

### design/ssba_cfg_if.sv
// ----------------------------------------------------------------------------
// ssba_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface ssba_cfg_if import ssba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/ssba_ctrl.sv
// ----------------------------------------------------------------------------
// ssba_ctrl
// sequencer: accept, select word, read-modify-write, hand off result
// ----------------------------------------------------------------------------
module ssba_ctrl import ssba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  sts_t sts,
  output logic req_ready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEL,
    S_MOD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (sts.kind == KIND_FREE) begin
            cmd.rd_input = 1'b1;
            state_next   = S_MOD;
          end else begin
            state_next = S_SEL;
          end
        end
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (sts.out_room) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/ssba_dp.sv
// ----------------------------------------------------------------------------
// ssba_dp
// bitmap memory, full-word summary, two-level first-fit search, result reg
// ----------------------------------------------------------------------------
module ssba_dp import ssba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_kind,
  input  logic [SLOT_W-1:0]     req_slot,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output logic                  rsp_ok,
  output logic [SLOT_W-1:0]     rsp_slot_index,
  output logic                  rsp_enabled
);

  // registers
  logic [TOTAL_W-1:0] total_slots;
  logic               swap_ready;

  // bitmap store; rows never written read as zero
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_valid;
  logic [MAP_WORDS-1:0] row_full;
  logic [WORD_BITS-1:0] rdata;
  logic                 rdata_ok;

  // item context
  logic              cur_kind;
  logic              cur_in_range;
  logic [BIT_AW-1:0] cur_bit;
  logic [MAP_AW-1:0] word_idx;
  logic              hit;

  // search
  logic [USE_W-1:0]  usable;
  logic [USE_W-1:0]  groups;
  logic [MAP_WORDS-1:0] cand;
  logic [SEG_N-1:0]  seg_hit_d;
  logic [SEG_AW-1:0] seg_loc_d [SEG_N];
  logic [SEG_N-1:0]  seg_hit;
  logic [SEG_AW-1:0] seg_loc [SEG_N];
  logic              sel_hit;
  logic [MAP_AW-1:0] sel_idx;
  logic              rd_en;
  logic [MAP_AW-1:0] rd_addr;

  // commit
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] new_word;
  logic [BIT_AW-1:0]    alloc_bit;
  logic                 wr_en;
  logic                 res_ok;
  logic [SLOT_W-1:0]    res_idx;

  assign usable = usable_total(total_slots);
  assign groups = usable >> BIT_AW;

  assign sts.kind     = req_kind;
  assign sts.out_room = !rsp_valid || rsp_ready;

  // word candidates: not full and inside a complete group below the total
  always_comb begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      cand[w] = !row_full[w] && (32'(w) < 32'(groups));
    end
    for (int s = 0; s < SEG_N; s++) begin
      seg_hit_d[s] = |cand[s*SEG_SIZE +: SEG_SIZE];
      seg_loc_d[s] = '0;
      for (int i = SEG_SIZE - 1; i >= 0; i--) begin
        if (cand[s*SEG_SIZE + i]) begin
          seg_loc_d[s] = SEG_AW'(i);
        end
      end
    end
  end

  // second level over segment summaries
  always_comb begin
    sel_hit = 1'b0;
    sel_idx = '0;
    for (int s = SEG_N - 1; s >= 0; s--) begin
      if (seg_hit[s]) begin
        sel_hit = 1'b1;
        sel_idx = MAP_AW'(s * SEG_SIZE + int'(seg_loc[s]));
      end
    end
  end

  assign rd_en   = cmd.rd_input || cmd.sel;
  assign rd_addr = cmd.rd_input ? MAP_AW'(req_slot >> BIT_AW) : sel_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seg_hit      <= seg_hit_d;
      seg_loc      <= seg_loc_d;
      cur_kind     <= req_kind;
      cur_in_range <= 32'(req_slot) < 32'(usable);
      cur_bit      <= req_slot[BIT_AW-1:0];
      word_idx     <= MAP_AW'(req_slot >> BIT_AW);
      hit          <= 1'b0;
    end else if (cmd.sel) begin
      word_idx <= sel_idx;
      hit      <= sel_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata    <= map_mem[rd_addr];
      rdata_ok <= row_valid[rd_addr];
    end
  end

  // modify
  always_comb begin
    cur_word  = rdata_ok ? rdata : '0;
    alloc_bit = first_zero(cur_word);
    if (cur_kind == KIND_ALLOC) begin
      new_word = cur_word | (WORD_BITS'(1) << alloc_bit);
      wr_en    = hit;
      res_ok   = hit;
      res_idx  = hit ? SLOT_W'({word_idx, alloc_bit}) : '0;
    end else begin
      new_word = cur_word & ~(WORD_BITS'(1) << cur_bit);
      wr_en    = cur_in_range;
      res_ok   = cur_in_range;
      res_idx  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      map_mem[word_idx] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (cmd.commit && wr_en) begin
      row_valid[word_idx] <= 1'b1;
      row_full[word_idx]  <= &new_word;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_slots <= '0;
      swap_ready  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOTAL_SLOTS: total_slots <= TOTAL_W'(cfg_data);
        REG_SWAP_READY:  swap_ready  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_ok         <= res_ok;
      rsp_slot_index <= res_idx;
      rsp_enabled    <= swap_ready;
    end
  end

endmodule

### design/swap_slot_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// first-fit swap slot allocator over a 4096-slot usage bitmap
// ----------------------------------------------------------------------------
//  channel  dir  payload                          accepted when
//  req      in   kind, slot                       req.valid & req.ready
//  rsp      out  ok, slot_index, enabled          rsp.valid & rsp.ready
//  cfg      in   index, data                      cfg.valid & cfg.ready
//
//  allocate: accept loads the group summary, then word select and read, then
//  bit pick and write-back; free: word read at accept, then write-back
//  one item in flight; the single-port bitmap read-modify-write sets the pace
//  reset clears the registers and the per-word valid and full flags at once,
//  so the bitmap reads as all free with no clearing pass
//  a stalled result sits in the output register; the next item is taken and
//  waits at write-back until that register drains
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator import ssba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ssba_req_if.sink   req,
  ssba_rsp_if.source rsp,
  ssba_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer
  ssba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // bitmap, search and result register
  ssba_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_kind       (req.kind),
    .req_slot       (req.slot),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .cmd            (cmd),
    .sts            (sts),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ok         (rsp.ok),
    .rsp_slot_index (rsp.slot_index),
    .rsp_enabled    (rsp.enabled)
  );

endmodule

### design/ssba_checker.sv
// ----------------------------------------------------------------------------
// ssba_checker
// port-level checks on the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "swap_slot_bitmap_allocator_assert.svh"

module ssba_checker import ssba_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_ok,
  input logic [SLOT_W-1:0]     rsp_slot_index,
  input logic                  rsp_enabled,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0] outstanding;
  logic       ready_shadow;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 2'd1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_shadow <= 1'b0;
    end else if (cfg_valid && cfg_ready && (cfg_index == REG_SWAP_READY)) begin
      ready_shadow <= cfg_data[0];
    end
  end

  `SSBA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_slot_index) && $stable(rsp_enabled))
  `SSBA_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp_ok, rsp_slot_index == '0)
  `SSBA_ASSERT_IMP(a_in_flight, 1'b1, (outstanding <= 2'd2) && (!rsp_valid || (outstanding != 2'd0)))
  `SSBA_ASSERT_IMP(a_enabled, rsp_valid, rsp_enabled == ready_shadow)
  `SSBA_ASSERT_RST(a_reset_idle, rst, !rsp_valid)

endmodule

bind swap_slot_bitmap_allocator ssba_checker u_ssba_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_ok         (rsp.ok),
  .rsp_slot_index (rsp.slot_index),
  .rsp_enabled    (rsp.enabled),
  .cfg_valid      (cfg.valid),
  .cfg_ready      (cfg.ready),
  .cfg_index      (cfg.index),
  .cfg_data       (cfg.data)
);

### verif/tb_swap_slot_bitmap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swap_slot_bitmap_allocator
// drives allocate and free items through the slot allocator under several
// usable totals, predicts every result from a shadow copy of the usage bitmap
// and checks each returned item field by field, in order
// ----------------------------------------------------------------------------
module tb_swap_slot_bitmap_allocator;
  import ssba_pkg::*;

  // generous cycle budget, many times what ~1300 items need
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
  } slot_item_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_index;
    logic              enabled;
  } slot_result_t;

  logic clk;
  logic rst;

  ssba_req_if req_ch ();
  ssba_rsp_if rsp_ch ();
  ssba_cfg_if cfg_ch ();

  swap_slot_bitmap_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // shadow state: usage bitmap and the two registers
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [TOTAL_W-1:0]   shadow_total;
  logic                 shadow_ready;

  slot_item_t   stim_q [$];      // items waiting for the driver
  slot_result_t expected_q [$];  // predicted results, oldest first
  slot_item_t   next_item;
  slot_item_t   taken_item;
  slot_result_t seen_result;
  slot_result_t want_result;

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int cycle_count;

  // 2 ns clock
  always #1 clk = ~clk;

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // first-fit allocate or bounded free on the shadow bitmap, returns the
  // result the block should give for this item
  function automatic slot_result_t apply_request(input slot_item_t it);
    slot_result_t r;
    int usable;
    int groups;
    bit hit;
    r = '0;
    r.enabled = shadow_ready;
    hit = 1'b0;
    // usable total clamps at the store size
    usable = (int'(shadow_total) < SLOT_COUNT) ? int'(shadow_total) : SLOT_COUNT;
    if (it.kind == KIND_ALLOC) begin
      // only complete groups of 32 below the total take part
      groups = usable / WORD_BITS;
      for (int w = 0; w < groups && w < MAP_WORDS; w++) begin
        if (!hit && shadow_map[w] != '1) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (!hit && !shadow_map[w][b]) begin
              shadow_map[w][b] = 1'b1;
              r.ok = 1'b1;
              r.slot_index = SLOT_W'(w * WORD_BITS + b);
              hit = 1'b1;
            end
          end
        end
      end
    end else if (int'(it.slot) < usable) begin
      // freeing an already free slot still reports ok
      shadow_map[it.slot / WORD_BITS][it.slot % WORD_BITS] = 1'b0;
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: predicts at acceptance, then offers the next queued item
  // unless it rolls an idle cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken_item.kind = req_ch.kind;
        taken_item.slot = req_ch.slot;
        expected_q.push_back(apply_request(taken_item));
      end
      // channel is free when nothing is offered or the offer was just taken
      if (!req_ch.valid || req_ch.ready) begin
        if (stim_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = stim_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.kind  <= next_item.kind;
          req_ch.slot  <= next_item.slot;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random back-pressure, in-order compare against the oldest
  // prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_result.ok         = rsp_ch.ok;
        seen_result.slot_index = rsp_ch.slot_index;
        seen_result.enabled    = rsp_ch.enabled;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result ok=%0b slot_index=%0d enabled=%0b",
                                    seen_result.ok, seen_result.slot_index,
                                    seen_result.enabled));
        end else begin
          want_result = expected_q.pop_front();
          if (seen_result.ok !== want_result.ok)
            report_mismatch($sformatf("ok got %0b want %0b",
                                      seen_result.ok, want_result.ok));
          if (seen_result.slot_index !== want_result.slot_index)
            report_mismatch($sformatf("slot_index got %0d want %0d",
                                      seen_result.slot_index, want_result.slot_index));
          if (seen_result.enabled !== want_result.enabled)
            report_mismatch($sformatf("enabled got %0b want %0b",
                                      seen_result.enabled, want_result.enabled));
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // register write; shadow copy follows at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_TOTAL_SLOTS) begin
      shadow_total = val[TOTAL_W-1:0];
    end else begin
      shadow_ready = val[0];
    end
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    do @(negedge clk);
    while (!(stim_q.size() == 0 && !req_ch.valid && expected_q.size() == 0));
  endtask

  task automatic push_item(input logic kind, input int slot);
    slot_item_t it;
    it.kind = kind;
    it.slot = SLOT_W'(slot);
    stim_q.push_back(it);
  endtask

  // random item: frees mostly land in the low, busy region below the total,
  // some anywhere in the field so that out-of-range frees occur
  task automatic push_random(input int usable, input int alloc_pct);
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    span = (usable < 160) ? usable : 160;
    if (usable == 0 || roll < 15) begin
      push_item(($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE,
                $urandom_range(0, 4095));
    end else if (roll < 75) begin
      push_item(($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE,
                $urandom_range(0, span - 1));
    end else begin
      push_item(($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE,
                $urandom_range(0, usable - 1));
    end
  endtask

  // one register setting, random traffic, with a full hold-off halfway through
  task automatic run_phase(input int total, input bit ready_flag,
                           input int count, input int alloc_pct);
    int usable;
    usable = (total < SLOT_COUNT) ? total : SLOT_COUNT;
    write_reg(REG_TOTAL_SLOTS, CFG_DATA_W'(total));
    write_reg(REG_SWAP_READY, CFG_DATA_W'(ready_flag));
    for (int i = 0; i < count; i++) begin
      push_random(usable, alloc_pct);
      if (i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    // every block input known from time zero
    clk          = 1'b0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_ALLOC;
    req_ch.slot  = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TOTAL_SLOTS;
    cfg_ch.data  = '0;
    error_count  = 0;
    cycle_count  = 0;
    shadow_total = '0;
    shadow_ready = 1'b0;
    for (int w = 0; w < MAP_WORDS; w++) shadow_map[w] = '0;

    // sender seldom idle, receiver often stalls
    send_idle_pct = 16;
    recv_idle_pct = 61;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at reset: total zero, so allocate fails and every free is ignored
    push_item(KIND_ALLOC, 0);
    push_item(KIND_FREE, 0);
    push_item(KIND_FREE, 4095);
    wait_drained();

    // total above the store size clamps to 4096; free of a free slot is ok;
    // slot field is ignored on allocate
    write_reg(REG_TOTAL_SLOTS, CFG_DATA_W'(8191));
    write_reg(REG_SWAP_READY, CFG_DATA_W'(1));
    push_item(KIND_ALLOC, 0);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_FREE, 0);
    push_item(KIND_FREE, 0);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_FREE, 4095);
    push_item(KIND_ALLOC, 4095);
    wait_drained();

    // total below one group: allocate fails, free just under the total works,
    // free at the total is flagged; not ready does not block allocation
    write_reg(REG_TOTAL_SLOTS, CFG_DATA_W'(31));
    write_reg(REG_SWAP_READY, CFG_DATA_W'(0));
    push_item(KIND_ALLOC, 0);
    push_item(KIND_FREE, 30);
    push_item(KIND_FREE, 31);
    wait_drained();

    // partial top group: slots 32..39 can be freed but never handed out
    write_reg(REG_TOTAL_SLOTS, CFG_DATA_W'(40));
    write_reg(REG_SWAP_READY, CFG_DATA_W'(1));
    push_item(KIND_ALLOC, 0);
    push_item(KIND_FREE, 35);
    push_item(KIND_FREE, 40);
    push_item(KIND_FREE, 39);
    wait_drained();

    // random traffic; small totals run out of slots and exercise the full path
    run_phase(4096, 1'b1, 260, 70);
    run_phase(64, 1'b0, 200, 60);

    // roles swapped: sender idles a lot, receiver rarely stalls
    send_idle_pct = 61;
    recv_idle_pct = 16;
    run_phase(100, 1'b1, 200, 55);
    run_phase(1000, 1'b0, 180, 50);
    run_phase(32, 1'b1, 150, 60);

    // back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(8191, 1'b1, 160, 50);
    run_phase(0, 1'b0, 40, 50);
    run_phase(4000, 1'b1, 100, 65);

    // let any stray result show up before the verdict
    wait_drained();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
